[hw/rtl/lpfd_pkg.sv]
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

	// Header layout, byte offsets within the little-endian header
	localparam int HEADER_BYTES = 12;
	localparam int MAGIC_END    = 4;
	localparam int VERSION_END  = 6;
	localparam int OPCODE_END   = 8;

	localparam int HCNT_W = $clog2(HEADER_BYTES);

	localparam logic [HCNT_W-1:0] HCNT_MAGIC_END   = HCNT_W'(MAGIC_END);
	localparam logic [HCNT_W-1:0] HCNT_VERSION_END = HCNT_W'(VERSION_END);
	localparam logic [HCNT_W-1:0] HCNT_OPCODE_END  = HCNT_W'(OPCODE_END);
	localparam logic [HCNT_W-1:0] HCNT_LAST        = HCNT_W'(HEADER_BYTES - 1);

	// Reset value of the maximum payload register
	localparam logic [30:0] MAX_PAYLOAD_RESET = 31'd65536;

	// Result kinds
	typedef enum logic [2:0] {
		ST_PAYLOAD     = 3'd0,
		ST_EMPTY       = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_TOO_BIG     = 3'd4
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAGIC   = 2'd0,
		CFG_VERSION = 2'd1,
		CFG_MAXLEN  = 2'd2,
		CFG_UNUSED  = 2'd3
	} cfg_idx_t;

endpackage

[hw/rtl/length_prefixed_frame_deframer.sv]
// Top level of the length-prefixed frame deframer.
//
// Takes one stream byte per cycle and gathers a 12-byte little-endian header
// (magic, version, opcode, payload length). On the last header byte the magic,
// the version and the length against max_payload are checked in that order;
// the first failure gives one error item with tlast set and a new header
// starts. A valid zero-length header gives one empty-frame item; otherwise the
// following payload bytes are passed out one for one with the frame's opcode
// and length, the final byte marked by tlast. The
// header registers and the 32-bit remaining-byte counter are updated in the
// cycle the byte is accepted and the result lands in a single output
// register, so a byte is accepted every cycle while that register is empty or
// being drained. Configuration writes are always accepted and apply from the
// next header check on.
module length_prefixed_frame_deframer
	import lpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [15:0] opcode, [23:16] payload_byte,
	                                    // [55:24] frame_length
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	output logic        m_axis_tlast,   // last_of_frame
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers
	logic [31:0] exp_magic_q;
	logic [15:0] exp_version_q;
	logic [30:0] max_payload_q;

	// Deframer state
	logic              in_payload_q;
	logic [HCNT_W-1:0] hdr_cnt_q;
	logic [31:0]       magic_q;
	logic [15:0]       version_q;
	logic [15:0]       opcode_q;
	logic [31:0]       length_q;
	logic [31:0]       remaining_q;

	// Output register
	logic        out_valid_q;
	status_t     out_status_q;
	logic [15:0] out_opcode_q;
	logic [7:0]  out_byte_q;
	logic [31:0] out_length_q;
	logic        out_last_q;

	logic        in_acc;
	logic [31:0] length_next;
	logic        hdr_done;
	logic        emit;
	status_t     emit_status;
	logic        emit_last;
	logic [31:0] remaining_dec;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign length_next   = {s_axis_tdata, length_q[31:8]};
	assign hdr_done      = (hdr_cnt_q >= HCNT_LAST);
	assign remaining_dec = remaining_q - 32'd1;

	// Decide the result of the current byte
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_PAYLOAD;
		emit_last   = 1'b1;
		if (in_payload_q) begin
			emit      = 1'b1;
			emit_last = (remaining_dec == 32'd0);
		end else if (hdr_done) begin
			emit = 1'b1;
			if (magic_q != exp_magic_q) begin
				emit_status = ST_BAD_MAGIC;
			end else if (version_q != exp_version_q) begin
				emit_status = ST_BAD_VERSION;
			end else if (length_next > {1'b0, max_payload_q}) begin
				emit_status = ST_TOO_BIG;
			end else if (length_next == 32'd0) begin
				emit_status = ST_EMPTY;
			end else begin
				emit = 1'b0;
			end
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= '0;
			exp_version_q <= '0;
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAGIC:   exp_magic_q   <= cfg_data;
				CFG_VERSION: exp_version_q <= cfg_data[15:0];
				CFG_MAXLEN:  max_payload_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Advance the header collector and payload counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			magic_q      <= '0;
			version_q    <= '0;
			opcode_q     <= '0;
			length_q     <= '0;
			remaining_q  <= '0;
		end else if (in_acc) begin
			if (in_payload_q) begin
				remaining_q <= remaining_dec;
				if (remaining_dec == 32'd0) begin
					in_payload_q <= 1'b0;
					hdr_cnt_q    <= '0;
				end
			end else begin
				if (hdr_cnt_q < HCNT_MAGIC_END) begin
					magic_q <= {s_axis_tdata, magic_q[31:8]};
				end else if (hdr_cnt_q < HCNT_VERSION_END) begin
					version_q <= {s_axis_tdata, version_q[15:8]};
				end else if (hdr_cnt_q < HCNT_OPCODE_END) begin
					opcode_q <= {s_axis_tdata, opcode_q[15:8]};
				end else begin
					length_q <= length_next;
				end
				if (hdr_done) begin
					hdr_cnt_q <= '0;
					if (!emit) begin
						remaining_q  <= length_next;
						in_payload_q <= 1'b1;
					end
				end else begin
					hdr_cnt_q <= hdr_cnt_q + HCNT_W'(1);
				end
			end
		end
	end

	// Track output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			out_status_q <= emit_status;
			out_opcode_q <= opcode_q;
			out_byte_q   <= in_payload_q ? s_axis_tdata : 8'd0;
			out_length_q <= (in_payload_q) ? length_q : length_next;
			out_last_q   <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_length_q, out_byte_q, out_opcode_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// Checks on the deframer's own logic
	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (remaining_q != 32'd0))
		else $error("payload phase with no bytes remaining");

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HCNT_LAST)
		else $error("header counter out of range");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_PAYLOAD)) |-> m_axis_tlast)
		else $error("error or empty-frame item without tlast");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_payload_q && (remaining_q == 32'd1)) |=>
		(!in_payload_q && (hdr_cnt_q == '0)))
		else $error("frame did not end after its final payload byte");

	a_no_payload_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_payload_q && emit) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("header result not marked as last");

endmodule
